// ===== hw/rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: request and
// response structs, request kinds, status codes and the cell-row command.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 5;
   localparam int OCC_W  = 5;
   localparam int VAL_W  = 32;
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [2:0] {
      REQ_INS_FIRST = 3'd0,
      REQ_INS_LAST  = 3'd1,
      REQ_INS_AT    = 3'd2,
      REQ_DEL_FIRST = 3'd3,
      REQ_DEL_LAST  = 3'd4,
      REQ_DEL_AT    = 3'd5,
      REQ_COUNT     = 3'd6,
      REQ_DUMP      = 3'd7
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_BADPOS = 2'd1,
      STAT_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      req_kind_type             req_type;
      logic signed [VAL_W-1:0]  value;
      logic [POS_W-1:0]         position;
   } req_payload_type;

   typedef struct packed {
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
      logic signed [VAL_W-1:0]  element;
      logic                     has_element;
      logic                     last;
   } rsp_payload_type;

   // Command broadcast to every cell of the row.
   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_ROTATE = 2'd3
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type               op;
      logic [IDX_W-1:0]         idx;
      logic [DATA_WIDTH-1:0]    data;
   } cmd_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_DUMP = 1'b1
   } state_type;

endpackage

// ===== hw/rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list cell: holds one entry and, on each command, keeps it, loads the
// broadcast data, or takes the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module ple_cell
   import ple_pkg::*;
(
   input  logic                  clock,
   input  logic [IDX_W-1:0]      cell_index,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data_out
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CMD_INSERT: begin
            if (cell_index == cmd.idx) begin
               data_in = cmd.data;
            end else if (cell_index > cmd.idx) begin
               data_in = left_data;
            end
         end
         CMD_DELETE: begin
            if (cell_index >= cmd.idx) begin
               data_in = right_data;
            end
         end
         CMD_ROTATE: begin
            // the last occupied cell wraps around to the head entry
            if (cell_index == cmd.idx) begin
               data_in = cmd.data;
            end else begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== hw/rtl/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl
// Request decode, position checks, fill count and dump sequencing. Drives
// the command to the cell row and registers every response.
// ----------------------------------------------------------------------------
module ple_ctrl
   import ple_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  req_payload_type       req_payload,
   input  logic [DATA_WIDTH-1:0] head_data,
   output logic                  busy,
   output cmd_type               cmd,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic             accept;
   logic             full;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             ins_pos_ok;
   logic             del_pos_ok;
   logic [IDX_W-1:0] tail_idx;

   assign accept     = start && (state_ff == S_IDLE);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign pos_ext    = CMP_W'(req_payload.position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
   assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign tail_idx   = IDX_W'(count_ff - CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_payload.req_type == REQ_DUMP) && (count_ff != '0)) begin
               state_in = S_DUMP;
            end
         end
         S_DUMP: begin
            if (left_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs, command and counters
   always_comb begin
      cmd.op               = CMD_HOLD;
      cmd.idx              = '0;
      cmd.data             = DATA_WIDTH'($unsigned(req_payload.value));
      count_in             = count_ff;
      left_in              = left_ff;
      rsp_valid_in         = 1'b0;
      rsp_in.status        = STAT_OK;
      rsp_in.element       = '0;
      rsp_in.has_element   = 1'b0;
      rsp_in.last          = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_payload.req_type)
                  REQ_INS_FIRST, REQ_INS_LAST: begin
                     if (full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        cmd.op   = CMD_INSERT;
                        cmd.idx  = (req_payload.req_type == REQ_INS_FIRST) ?
                                   '0 : IDX_W'(count_ff);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_INS_AT: begin
                     if (!ins_pos_ok) begin
                        rsp_in.status = STAT_BADPOS;
                     end else if (full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        cmd.op   = CMD_INSERT;
                        cmd.idx  = IDX_W'(pos_ext - CMP_W'(1));
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_DEL_FIRST, REQ_DEL_LAST: begin
                     if (count_ff != '0) begin
                        cmd.op   = CMD_DELETE;
                        cmd.idx  = (req_payload.req_type == REQ_DEL_FIRST) ?
                                   '0 : tail_idx;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  REQ_DEL_AT: begin
                     if (!del_pos_ok) begin
                        rsp_in.status = STAT_BADPOS;
                     end else begin
                        cmd.op   = CMD_DELETE;
                        cmd.idx  = IDX_W'(pos_ext - CMP_W'(1));
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  REQ_DUMP: begin
                     // a non-empty list streams its entries from the dump state instead
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        left_in      = count_ff;
                     end
                  end
                  default: begin
                     rsp_in.status = STAT_OK;
                  end
               endcase
            end
         end
         S_DUMP: begin
            // emit the head, rotate the row by one place
            cmd.op             = CMD_ROTATE;
            cmd.idx            = tail_idx;
            cmd.data           = head_data;
            rsp_valid_in       = 1'b1;
            rsp_in.element     = VAL_W'(head_data);
            rsp_in.has_element = 1'b1;
            rsp_in.last        = (left_ff == CNT_W'(1));
            left_in            = left_ff - CNT_W'(1);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
      rsp_in.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy        = (state_ff == S_DUMP);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_dump_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |=> (rsp_valid_ff && rsp_ff.has_element))
      else $error("dump cycle without an entry response");

   a_dump_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |=> $stable(count_ff))
      else $error("fill count changed during dump");

   a_dump_left_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> ((left_ff != '0) && (left_ff <= count_ff)))
      else $error("dump counter out of range");

   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> (state_ff == S_DUMP))
      else $error("non-final response outside a dump");

endmodule

// ===== hw/rtl/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of up to DEPTH signed entries held in a row of shifting cells.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with start high and busy low. Every
// insert, delete and count request is done at the edge that takes it: the whole
// cell row shifts in parallel, and its single response appears on rsp_payload
// with rsp_valid high in the next cycle, so such requests can be issued every cycle.
// A dump of N > 0 entries holds busy high while it runs and emits one entry
// response per cycle (the row rotates one place a cycle, the head cell feeds
// the output), the last one flagged by last; an empty dump gives one response.
// Responses are shown for exactly one cycle and the receiver cannot stall them.
// Out-of-range positions report invalid position, inserts into a full list
// report full; in both cases the list is left as it was.
// ----------------------------------------------------------------------------
module positional_list_engine_unit
   import ple_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  req_payload_type req_payload,
   output logic            busy,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   cmd_type               cmd;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   // decode, count and sequence the row
   ple_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .head_data   (cell_data[0]),
      .busy        (busy),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // row of cells in list order, cell 0 holds the first entry
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = cmd.data;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      ple_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[i])
      );
   end

endmodule

// ===== sim/tb_positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Self-checking bench for the positional list engine. A shadow copy of the
// list predicts the status, occupancy and dumped entries of every accepted
// request, and each response strobe is compared field by field with the
// oldest outstanding prediction. A directed pass covers empty-list corner
// cases, bad positions and extreme values. A random pass then swings the list
// between empty and full, with random idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_unit
   import ple_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200_000;
   localparam int RANDOM_ITEMS = 360;

   // -------------------------------------------------------------------------
   // Shadow list and response scoreboard.
   // note_request() updates the shadow list for an accepted transaction and
   // queues the responses it must produce; check_response() pops and compares.
   // -------------------------------------------------------------------------
   class list_shadow_board;
      logic [DATA_WIDTH-1:0] shadow_cells [DEPTH];
      int unsigned           shadow_fill;
      rsp_payload_type       awaited_responses [$];
      int unsigned           mismatch_count;

      function new();
         shadow_fill    = 0;
         mismatch_count = 0;
      endfunction

      function int unsigned fill_level();
         return shadow_fill;
      endfunction

      function int unsigned outstanding();
         return awaited_responses.size();
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      // Queue one response; occupancy always reflects the list after the request.
      function void push_response(status_type st, logic [VAL_W-1:0] elem,
                                  logic has, logic fin);
         rsp_payload_type r;
         r.status      = st;
         r.occupancy   = OCC_W'(shadow_fill);
         r.element     = elem;
         r.has_element = has;
         r.last        = fin;
         awaited_responses.push_back(r);
      endfunction

      // Insert so that the value becomes entry number pos (1-based).
      function status_type put_entry(int unsigned pos, logic [VAL_W-1:0] v);
         if (pos < 1 || pos > shadow_fill + 1) return STAT_BADPOS;
         if (shadow_fill >= DEPTH) return STAT_FULL;
         for (int i = int'(shadow_fill); i >= int'(pos); i--)
            shadow_cells[i] = shadow_cells[i-1];
         shadow_cells[pos-1] = v[DATA_WIDTH-1:0];
         shadow_fill++;
         return STAT_OK;
      endfunction

      // Remove entry number pos (1-based).
      function status_type drop_entry(int unsigned pos);
         if (pos < 1 || pos > shadow_fill) return STAT_BADPOS;
         for (int unsigned i = pos - 1; i + 1 < shadow_fill; i++)
            shadow_cells[i] = shadow_cells[i+1];
         shadow_fill--;
         return STAT_OK;
      endfunction

      function void note_request(req_payload_type rq);
         status_type       st;
         logic [VAL_W-1:0] cell_word;
         st = STAT_OK;
         case (rq.req_type)
            REQ_INS_FIRST: st = put_entry(1, rq.value);
            REQ_INS_LAST:  st = put_entry(shadow_fill + 1, rq.value);
            REQ_INS_AT:    st = put_entry(32'(rq.position), rq.value);
            REQ_DEL_FIRST: if (shadow_fill > 0) st = drop_entry(1);
            REQ_DEL_LAST:  if (shadow_fill > 0) st = drop_entry(shadow_fill);
            REQ_DEL_AT:    st = drop_entry(32'(rq.position));
            REQ_COUNT:     st = STAT_OK;
            REQ_DUMP: begin
               if (shadow_fill == 0) begin
                  push_response(STAT_OK, '0, 1'b0, 1'b1);
               end else begin
                  for (int unsigned i = 0; i < shadow_fill; i++) begin
                     cell_word = '0;
                     cell_word = shadow_cells[i];
                     push_response(STAT_OK, cell_word, 1'b1, (i + 1 == shadow_fill));
                  end
               end
               return;
            end
            default: st = STAT_OK;
         endcase
         push_response(st, '0, 1'b0, 1'b1);
      endfunction

      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited_responses.size() == 0) begin
            report_mismatch("response with nothing outstanding");
            return;
         end
         want = awaited_responses.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d want %0d",
                                      got.occupancy, want.occupancy));
         if (got.element !== want.element)
            report_mismatch($sformatf("element got %0h want %0h",
                                      got.element, want.element));
         if (got.has_element !== want.has_element)
            report_mismatch($sformatf("has_element got %0b want %0b",
                                      got.has_element, want.has_element));
         if (got.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block itself
   // -------------------------------------------------------------------------
   logic            clock;
   logic            reset;
   logic            start;
   req_payload_type req_payload;
   logic            busy;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;

   list_shadow_board sb;
   bit               idle_enabled;
   int unsigned      cycle_count;

   positional_list_engine_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: end the run with errors once the cycle count reaches CYCLE_LIMIT.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_positional_list_engine_unit: errors");
         $finish;
      end
   end

   // Sample the response strobe at the rising edge; the receiver cannot stall,
   // so every strobed cycle is one response transaction.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         sb.check_response(rsp_payload);
   end

   // -------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------

   // Drive one request transaction: insert random idle cycles if enabled, then hold start
   // high until a rising edge finds busy low, and note the request there.
   task automatic send_request(input req_payload_type item);
      @(negedge clock);
      while (idle_enabled && $urandom_range(99) < 34) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(item);
   endtask

   function automatic req_payload_type make_request(req_kind_type kind,
                                                    logic [VAL_W-1:0] v,
                                                    logic [POS_W-1:0] pos);
      req_payload_type r;
      r.req_type = kind;
      r.value    = v;
      r.position = pos;
      return r;
   endfunction

   // Favor the extremes of the signed range now and then.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Build one random request. Most are well-formed for the current fill level,
   // leaning toward inserts while growing and deletes while shrinking; the rest
   // are noise with any kind and any position.
   function automatic req_payload_type pick_request(bit growing, int unsigned fill);
      req_payload_type r;
      int unsigned     roll;
      int unsigned     insert_share;
      int unsigned     delete_share;
      r.value    = pick_value();
      r.position = POS_W'($urandom_range(31));
      roll       = $urandom_range(99);
      if (roll < 8) begin
         r.req_type = req_kind_type'(3'($urandom_range(7)));
         return r;
      end
      insert_share = growing ? 60 : 25;
      delete_share = growing ? 78 : 75;
      roll = $urandom_range(99);
      if (roll < insert_share) begin
         case ($urandom_range(2))
            0:       r.req_type = REQ_INS_FIRST;
            1:       r.req_type = REQ_INS_LAST;
            default: r.req_type = REQ_INS_AT;
         endcase
         if ($urandom_range(99) >= 15)
            r.position = POS_W'($urandom_range(fill + 1, 1));
      end else if (roll < delete_share) begin
         case ($urandom_range(2))
            0:       r.req_type = REQ_DEL_FIRST;
            1:       r.req_type = REQ_DEL_LAST;
            default: r.req_type = REQ_DEL_AT;
         endcase
         if (fill > 0 && $urandom_range(99) >= 15)
            r.position = POS_W'($urandom_range(fill, 1));
      end else if (roll < 88) begin
         r.req_type = REQ_COUNT;
      end else begin
         r.req_type = REQ_DUMP;
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus sequence
   // -------------------------------------------------------------------------
   initial begin
      bit growing;
      sb           = new();
      idle_enabled = 1'b1;
      growing      = 1'b1;

      // Hold every input at a known value while reset is high, then release reset.
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Empty list: dump, count, deletes that do nothing, and bad positions.
      send_request(make_request(REQ_DUMP,      32'h1234_5678, 5'd0));
      send_request(make_request(REQ_COUNT,     32'h0,         5'd31));
      send_request(make_request(REQ_DEL_FIRST, 32'h0,         5'd0));
      send_request(make_request(REQ_DEL_LAST,  32'h0,         5'd0));
      send_request(make_request(REQ_DEL_AT,    32'h0,         5'd0));
      send_request(make_request(REQ_DEL_AT,    32'h0,         5'd1));
      send_request(make_request(REQ_DEL_AT,    32'hFFFF_FFFF, 5'd31));
      send_request(make_request(REQ_INS_AT,    32'h5,         5'd0));
      send_request(make_request(REQ_INS_AT,    32'h5,         5'd2));

      // Grow with extreme values, then probe the end positions.
      send_request(make_request(REQ_INS_FIRST, 32'h7FFF_FFFF, 5'd0));
      send_request(make_request(REQ_INS_LAST,  32'h8000_0000, 5'd31));
      send_request(make_request(REQ_INS_AT,    32'hFFFF_FFFF, 5'd2));
      send_request(make_request(REQ_INS_AT,    32'h0000_0000, 5'd4));
      send_request(make_request(REQ_INS_AT,    32'hA5A5_5A5A, 5'd6));
      send_request(make_request(REQ_INS_AT,    32'h5A5A_A5A5, 5'd31));
      send_request(make_request(REQ_DEL_AT,    32'h0,         5'd5));
      send_request(make_request(REQ_COUNT,     32'h0,         5'd0));
      send_request(make_request(REQ_DUMP,      32'h0,         5'd0));
      send_request(make_request(REQ_DEL_AT,    32'h0,         5'd4));
      send_request(make_request(REQ_DEL_AT,    32'h0,         5'd2));
      send_request(make_request(REQ_DEL_FIRST, 32'h0,         5'd0));
      send_request(make_request(REQ_DEL_LAST,  32'h0,         5'd0));
      send_request(make_request(REQ_DUMP,      32'h0,         5'd0));

      // Random pass: swing the list between empty and full so that full-list
      // inserts and long dumps happen many times. Drop idle gaps for a stretch.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_enabled = !(n >= 140 && n < 220);
         if (sb.fill_level() == DEPTH && $urandom_range(2) == 0)
            growing = 1'b0;
         else if (sb.fill_level() == 0 && $urandom_range(1) == 0)
            growing = 1'b1;
         else if ($urandom_range(99) < 3)
            growing = !growing;
         send_request(pick_request(growing, sb.fill_level()));
      end

      // Release start, drain every outstanding response, then keep watching the
      // response strobe for any stray one.
      @(negedge clock);
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
         $display("tb_positional_list_engine_unit: clean");
      end else begin
         $display("tb_positional_list_engine_unit: errors");
      end
      $finish;
   end

endmodule
